// ----- sv/slfd_pkg.sv -----
// slfd_pkg: shared types, constants and the CRC-8 step of the frame deframer.
// No dependencies; every other file of the deframer uses it.

package slfd_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [BYTE_W-1:0] LENGTH_LIMIT = 8'd253;
   localparam logic [BYTE_W-1:0] MIN_LENGTH   = 8'd2;
   localparam logic [BYTE_W-1:0] CRC_POLY     = 8'hD5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_VALUE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_FIRST = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_SECOND = 2'd3;

   // register reset values
   localparam logic [BYTE_W-1:0] RST_SYNC_VALUE    = 8'd200;
   localparam logic [BYTE_W-1:0] RST_MAX_LENGTH    = 8'd62;
   localparam logic [BYTE_W-1:0] RST_ACCEPT_FIRST  = 8'd122;
   localparam logic [BYTE_W-1:0] RST_ACCEPT_SECOND = 8'd124;

   // byte kinds on the result channel
   localparam logic [KIND_W-1:0] KIND_TYPE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CRC     = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_value;
      logic [BYTE_W-1:0] max_length;
      logic [BYTE_W-1:0] accept_first;
      logic [BYTE_W-1:0] accept_second;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] rx_byte;
   } in_item_type;

   // CRC-8 DVB-S2, MSB first, one byte per call
   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] v;
      v = crc ^ b;
      for (int k = 0; k < BYTE_W; k++) begin
         if (v[BYTE_W-1]) begin
            v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[BYTE_W-2:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

// ----- sv/slfd_ifs.sv -----
// slfd_ifs: valid/ready channel interfaces of the deframer (input, result, csr).
// Depends on slfd_pkg.

interface slfd_req_if;
   logic                       valid;
   logic                       ready;
   logic [slfd_pkg::BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [slfd_pkg::BYTE_W-1:0] data_byte;
   logic [slfd_pkg::KIND_W-1:0] byte_kind;
   logic                        last;
   logic                        crc_good;
   logic                        type_accepted;
   logic [slfd_pkg::BYTE_W-1:0] frame_length;
   modport source (output valid, output data_byte, output byte_kind, output last,
                   output crc_good, output type_accepted, output frame_length,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_kind, input last,
                   input crc_good, input type_accepted, input frame_length,
                   output ready);
endinterface

interface slfd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [slfd_pkg::CSR_IDX_W-1:0] index;
   logic [slfd_pkg::BYTE_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/sync_length_frame_deframer_top.sv -----
// Channel   Dir  Payload                                         Item
// req_bus   in   rx_byte                                         one received byte
// rsp_bus   out  data_byte byte_kind last crc_good               one frame body byte
//                type_accepted frame_length
// csr_bus   in   index data                                      one register write
//
// Each byte passes through the input register, then the state/CRC update into the
// result register. One byte per cycle is sustained while the result is not stalled.
// Sync and length bytes produce no result. Synchronous active-high reset puts the
// block back to sync hunting and the registers to their defaults. A stalled result
// holds the input register, and req_bus.ready then drops.
// Depends on slfd_pkg, slfd_ifs, slfd_csr, slfd_in_reg and slfd_core.

module sync_length_frame_deframer_top (
   input  logic       clock,
   input  logic       reset,
   slfd_req_if.sink   req_bus,
   slfd_rsp_if.source rsp_bus,
   slfd_csr_if.sink   csr_bus
);

   slfd_pkg::cfg_type     cfg;
   slfd_pkg::in_item_type item;
   logic                  pop;

   slfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   slfd_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .pop     (pop),
      .item    (item)
   );

   slfd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (item),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- sv/slfd_csr.sv -----
// slfd_csr: configuration registers of the deframer, written over the csr channel.
// Depends on slfd_pkg and slfd_ifs.

module slfd_csr (
   input  logic              clock,
   input  logic              reset,
   slfd_csr_if.sink          csr_bus,
   output slfd_pkg::cfg_type cfg
);

   slfd_pkg::cfg_type cfg_ff;
   slfd_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            slfd_pkg::CSR_SYNC_VALUE:    cfg_in.sync_value    = csr_bus.data;
            slfd_pkg::CSR_MAX_LENGTH:    cfg_in.max_length    = csr_bus.data;
            slfd_pkg::CSR_ACCEPT_FIRST:  cfg_in.accept_first  = csr_bus.data;
            slfd_pkg::CSR_ACCEPT_SECOND: cfg_in.accept_second = csr_bus.data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value    <= slfd_pkg::RST_SYNC_VALUE;
         cfg_ff.max_length    <= slfd_pkg::RST_MAX_LENGTH;
         cfg_ff.accept_first  <= slfd_pkg::RST_ACCEPT_FIRST;
         cfg_ff.accept_second <= slfd_pkg::RST_ACCEPT_SECOND;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/slfd_in_reg.sv -----
// slfd_in_reg: input register stage; holds one received byte until the core takes it.
// Depends on slfd_pkg and slfd_ifs.

module slfd_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   slfd_req_if.sink              req_bus,
   input  logic                  pop,
   output slfd_pkg::in_item_type item
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [slfd_pkg::BYTE_W-1:0] byte_ff;
   logic                        take;

   assign req_bus.ready = !valid_ff || pop;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_bus.rx_byte;
      end
   end

   assign item.valid   = valid_ff;
   assign item.rx_byte = byte_ff;

endmodule

// ----- sv/slfd_core.sv -----
// slfd_core: sync/length hunting, CRC-8 over the frame body and the result register.
// Depends on slfd_pkg and slfd_ifs.

module slfd_core (
   input  logic                  clock,
   input  logic                  reset,
   input  slfd_pkg::cfg_type     cfg,
   input  slfd_pkg::in_item_type item,
   output logic                  pop,
   slfd_rsp_if.source            rsp_bus
);

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_TYPE = 2'd2,
      PH_BODY = 2'd3
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [slfd_pkg::BYTE_W-1:0] left_ff, left_in;
   logic [slfd_pkg::BYTE_W-1:0] crc_ff, crc_in;
   logic [slfd_pkg::BYTE_W-1:0] type_ff, type_in;
   logic [slfd_pkg::BYTE_W-1:0] length_ff, length_in;

   logic                        out_valid_ff, produce;
   logic [slfd_pkg::BYTE_W-1:0] out_data_ff;
   logic [slfd_pkg::KIND_W-1:0] out_kind_ff, kind_in;
   logic                        out_last_ff, last_in;
   logic                        out_crc_ok_ff, crc_ok_in;
   logic                        out_type_ok_ff, type_ok_in;
   logic [slfd_pkg::BYTE_W-1:0] out_length_ff;

   logic [slfd_pkg::BYTE_W-1:0] b;
   logic [slfd_pkg::BYTE_W-1:0] limit;
   logic [slfd_pkg::BYTE_W-1:0] crc_next;
   logic                        bad_length;

   // an item moves on whenever the result register is free or being drained
   assign pop = item.valid && (!out_valid_ff || rsp_bus.ready);
   assign b   = item.rx_byte;

   assign limit      = (cfg.max_length > slfd_pkg::LENGTH_LIMIT) ?
                       slfd_pkg::LENGTH_LIMIT : cfg.max_length;
   assign bad_length = (b < slfd_pkg::MIN_LENGTH) || (b > limit);
   // type byte starts from zero, which is the running value after a length byte
   assign crc_next   = slfd_pkg::crc8_step((phase_ff == PH_TYPE) ? '0 : crc_ff, b);

   always_comb begin
      phase_in   = phase_ff;
      left_in    = left_ff;
      crc_in     = crc_ff;
      type_in    = type_ff;
      length_in  = length_ff;
      produce    = 1'b0;
      kind_in    = slfd_pkg::KIND_PAYLOAD;
      last_in    = 1'b0;
      crc_ok_in  = 1'b0;
      type_ok_in = 1'b0;
      case (phase_ff)
         PH_LEN: begin
            if (bad_length) begin
               phase_in = PH_HUNT;
            end else begin
               length_in = b;
               left_in   = b;
               crc_in    = '0;
               phase_in  = PH_TYPE;
            end
         end
         PH_TYPE: begin
            type_in  = b;
            crc_in   = crc_next;
            left_in  = left_ff - 8'd1;
            phase_in = PH_BODY;
            produce  = 1'b1;
            kind_in  = slfd_pkg::KIND_TYPE;
         end
         PH_BODY: begin
            produce = 1'b1;
            if (left_ff <= 8'd1) begin
               kind_in    = slfd_pkg::KIND_CRC;
               last_in    = 1'b1;
               crc_ok_in  = (crc_ff == b);
               type_ok_in = (type_ff == cfg.accept_first) ||
                            (type_ff == cfg.accept_second);
               left_in    = '0;
               phase_in   = PH_HUNT;
            end else begin
               crc_in  = crc_next;
               left_in = left_ff - 8'd1;
            end
         end
         default: begin
            if (b == cfg.sync_value) begin
               phase_in = PH_LEN;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         left_ff      <= '0;
         crc_ff       <= '0;
         type_ff      <= '0;
         length_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff       <= phase_in;
            left_ff        <= left_in;
            crc_ff         <= crc_in;
            type_ff        <= type_in;
            length_ff      <= length_in;
            out_valid_ff   <= produce;
            out_data_ff    <= b;
            out_kind_ff    <= kind_in;
            out_last_ff    <= last_in;
            out_crc_ok_ff  <= crc_ok_in;
            out_type_ok_ff <= type_ok_in;
            out_length_ff  <= length_ff;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.data_byte     = out_data_ff;
   assign rsp_bus.byte_kind     = out_kind_ff;
   assign rsp_bus.last          = out_last_ff;
   assign rsp_bus.crc_good      = out_crc_ok_ff;
   assign rsp_bus.type_accepted = out_type_ok_ff;
   assign rsp_bus.frame_length  = out_length_ff;

endmodule
